// ----- sv/tzl_pkg.sv -----
package tzl_pkg;

   localparam int ZONES_DEFAULT = 8;

   localparam logic [7:0]  OWNED_MASK_RESET       = 8'd0;
   localparam logic [7:0]  SHARED_MASK_RESET      = 8'd255;
   localparam logic [15:0] RESPONSE_TIMEOUT_RESET = 16'd1000;
   localparam logic [15:0] RETRY_INTERVAL_RESET   = 16'd400;

   typedef enum logic [2:0] {
      KIND_POLL   = 3'd0,
      KIND_UNLOCK = 3'd1,
      KIND_DONATE = 3'd2,
      KIND_PEER   = 3'd3,
      KIND_STATUS = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      ZS_FREE        = 3'd0,
      ZS_MINE        = 3'd1,
      ZS_PENDING     = 3'd2,
      ZS_PEER_TRYING = 3'd3,
      ZS_PEER_OWNED  = 3'd4
   } zone_state_type;

   typedef enum logic [2:0] {
      ST_INIT        = 3'd0,
      ST_SEND        = 3'd1,
      ST_WAIT        = 3'd2,
      ST_LOCKED      = 3'd3,
      ST_TIMEOUT     = 3'd4,
      ST_ERROR       = 3'd5,
      ST_NO_RESPONSE = 3'd6
   } lock_step_type;

   typedef enum logic [1:0] {
      OUT_PROGRESS    = 2'd0,
      OUT_LOCKED      = 2'd1,
      OUT_NOT_HANDLED = 2'd2,
      OUT_NO_RESPONSE = 2'd3
   } outcome_type;

   typedef enum logic [1:0] {
      ORD_RESULT = 2'd0,
      ORD_TRY    = 2'd1,
      ORD_UNLOCK = 2'd2
   } order_type;

   typedef enum logic [1:0] {
      OWN_PEER   = 2'd0,
      OWN_MINE   = 2'd1,
      OWN_SHARED = 2'd2
   } owner_type;

   typedef enum logic [1:0] {
      CSR_OWNED_MASK       = 2'd0,
      CSR_SHARED_MASK      = 2'd1,
      CSR_RESPONSE_TIMEOUT = 2'd2,
      CSR_RETRY_INTERVAL   = 2'd3
   } csr_index_type;

   typedef enum logic {
      CTRL_IDLE = 1'b0,
      CTRL_EXEC = 1'b1
   } ctrl_state_type;

   typedef struct packed {
      logic capture;  // latch request beat and start table read
      logic commit;   // write table back and load result register
   } tzl_cmd_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  zone;
      logic [15:0] limit_ms;
      logic [31:0] now_ms;
      logic [1:0]  msg_order;
      logic        msg_grant;
   } req_payload_type;

   typedef struct packed {
      logic       send_valid;
      logic [1:0] send_order;
      logic [2:0] send_zone;
      logic       send_grant;
      logic [1:0] lock_outcome;
      logic [2:0] zone_status;
   } rsp_payload_type;

   typedef struct packed {
      logic           donate;
      zone_state_type state;
   } entry_type;

endpackage

// ----- sv/tzl_if.sv -----
interface tzl_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [7:0]  zone;
   logic [15:0] limit_ms;
   logic [31:0] now_ms;
   logic [1:0]  msg_order;
   logic        msg_grant;

   modport source (output valid, kind, zone, limit_ms, now_ms, msg_order, msg_grant,
                   input ready);
   modport sink (input valid, kind, zone, limit_ms, now_ms, msg_order, msg_grant,
                 output ready);
endinterface

interface tzl_rsp_if;
   logic       valid;
   logic       ready;
   logic       send_valid;
   logic [1:0] send_order;
   logic [2:0] send_zone;
   logic       send_grant;
   logic [1:0] lock_outcome;
   logic [2:0] zone_status;

   modport source (output valid, send_valid, send_order, send_zone, send_grant,
                   lock_outcome, zone_status, input ready);
   modport sink (input valid, send_valid, send_order, send_zone, send_grant,
                 lock_outcome, zone_status, output ready);
endinterface

// ----- sv/tzl_ctrl.sv -----
module tzl_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output tzl_pkg::tzl_cmd_type cmd
);
   import tzl_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           slot_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CTRL_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      // result register frees up in the same cycle its beat is taken
      slot_free   = !rsp_valid_ff || rsp_ready;
      unique case (state_ff)
         CTRL_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = CTRL_EXEC;
            end
         end
         CTRL_EXEC: begin
            if (slot_free) begin
               cmd.commit = 1'b1;
               state_in   = CTRL_IDLE;
            end
         end
      endcase
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_ready;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- sv/tzl_datapath.sv -----
module tzl_datapath #(
   parameter int ZONES = tzl_pkg::ZONES_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  tzl_pkg::tzl_cmd_type     cmd,
   input  tzl_pkg::req_payload_type req_data,
   output tzl_pkg::rsp_payload_type rsp_data,
   input  logic                     csr_we,
   input  logic [1:0]               csr_index,
   input  logic [15:0]              csr_wdata
);
   import tzl_pkg::*;

   localparam int ZW = (ZONES > 1) ? $clog2(ZONES) : 1;

   function automatic logic reached(input logic [31:0] now, input logic [31:0] base,
                                    input logic [31:0] delay);
      logic [31:0] due;
      due = base + delay;
      return now >= due;
   endfunction

   // configuration
   logic [7:0]  owned_mask_ff, shared_mask_ff;
   logic [15:0] response_timeout_ff, retry_interval_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         owned_mask_ff       <= OWNED_MASK_RESET;
         shared_mask_ff      <= SHARED_MASK_RESET;
         response_timeout_ff <= RESPONSE_TIMEOUT_RESET;
         retry_interval_ff   <= RETRY_INTERVAL_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_OWNED_MASK:       owned_mask_ff       <= csr_wdata[7:0];
            CSR_SHARED_MASK:      shared_mask_ff      <= csr_wdata[7:0];
            CSR_RESPONSE_TIMEOUT: response_timeout_ff <= csr_wdata;
            CSR_RETRY_INTERVAL:   retry_interval_ff   <= csr_wdata;
         endcase
      end
   end

   // zone table: entry memory plus per-entry valid bits, unwritten reads as free
   entry_type       tbl_mem [ZONES];
   logic [ZONES-1:0] tbl_valid_ff;
   entry_type       rd_entry_ff;
   logic            rd_hit_ff;
   req_payload_type req_ff;
   logic            zone_ok_in, zone_ok_ff;
   logic [ZW-1:0]   rd_addr, wr_addr;
   entry_type       cur, nxt;

   assign zone_ok_in = req_data.zone < 8'(ZONES);
   assign rd_addr    = zone_ok_in ? req_data.zone[ZW-1:0] : '0;
   assign wr_addr    = req_ff.zone[ZW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff      <= req_data;
         zone_ok_ff  <= zone_ok_in;
         rd_entry_ff <= tbl_mem[rd_addr];
         rd_hit_ff   <= tbl_valid_ff[rd_addr];
      end
      if (cmd.commit && zone_ok_ff) begin
         tbl_mem[wr_addr] <= nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tbl_valid_ff <= '0;
      end else if (cmd.commit && zone_ok_ff) begin
         tbl_valid_ff[wr_addr] <= 1'b1;
      end
   end

   // try-lock sequencer
   lock_step_type lock_step_ff, lock_step_in;
   logic [31:0]   last_try_ms_ff, last_try_ms_in;
   logic [31:0]   lock_begin_ms_ff, lock_begin_ms_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         lock_step_ff     <= ST_INIT;
         last_try_ms_ff   <= '0;
         lock_begin_ms_ff <= '0;
      end else if (cmd.commit) begin
         lock_step_ff     <= lock_step_in;
         last_try_ms_ff   <= last_try_ms_in;
         lock_begin_ms_ff <= lock_begin_ms_in;
      end
   end

   owner_type       own;
   rsp_payload_type rsp_in;
   rsp_payload_type rsp_ff;
   logic            hit_resp, hit_retry, hit_limit;

   always_comb begin
      if (req_ff.zone[7:3] != 5'd0) begin
         own = OWN_PEER;
      end else if (owned_mask_ff[req_ff.zone[2:0]]) begin
         own = OWN_MINE;
      end else if (shared_mask_ff[req_ff.zone[2:0]]) begin
         own = OWN_SHARED;
      end else begin
         own = OWN_PEER;
      end
   end

   assign hit_resp  = reached(req_ff.now_ms, lock_begin_ms_ff, 32'(response_timeout_ff));
   assign hit_retry = reached(req_ff.now_ms, last_try_ms_ff, 32'(retry_interval_ff));
   assign hit_limit = (req_ff.limit_ms != 16'd0) &&
                      reached(req_ff.now_ms, lock_begin_ms_ff, 32'(req_ff.limit_ms));

   always_comb begin
      if (rd_hit_ff) begin
         cur = rd_entry_ff;
      end else begin
         cur.donate = 1'b0;
         cur.state  = ZS_FREE;
      end
      nxt              = cur;
      lock_step_in     = lock_step_ff;
      last_try_ms_in   = last_try_ms_ff;
      lock_begin_ms_in = lock_begin_ms_ff;
      rsp_in           = '0;
      rsp_in.lock_outcome = OUT_PROGRESS;

      priority case (kind_type'(req_ff.kind))
         KIND_POLL: begin
            if (!zone_ok_ff) begin
               rsp_in.lock_outcome = OUT_NOT_HANDLED;
            end else begin
               unique case (lock_step_ff)
                  ST_INIT: begin
                     last_try_ms_in   = '0;
                     lock_begin_ms_in = req_ff.now_ms;
                     lock_step_in     = (own == OWN_MINE) ? ST_LOCKED : ST_SEND;
                  end
                  ST_SEND: begin
                     last_try_ms_in = req_ff.now_ms;
                     if (own == OWN_SHARED && cur.state != ZS_FREE) begin
                        lock_step_in = ST_ERROR;
                     end else begin
                        nxt.state         = (own == OWN_SHARED) ? ZS_MINE : ZS_PENDING;
                        rsp_in.send_valid = 1'b1;
                        rsp_in.send_order = ORD_TRY;
                        lock_step_in      = ST_WAIT;
                     end
                  end
                  ST_WAIT: begin
                     if (cur.state == ZS_MINE) begin
                        lock_step_in = ST_LOCKED;
                     end else if (cur.state == ZS_PENDING && hit_resp) begin
                        lock_step_in = ST_NO_RESPONSE;
                     end else if (cur.state == ZS_PENDING && hit_retry) begin
                        lock_step_in = ST_SEND;
                     end else if (hit_limit) begin
                        lock_step_in = ST_TIMEOUT;
                     end
                  end
                  ST_LOCKED: begin
                     lock_step_in        = ST_INIT;
                     rsp_in.lock_outcome = OUT_LOCKED;
                  end
                  ST_TIMEOUT: begin
                     nxt.state           = ZS_FREE;
                     nxt.donate          = 1'b0;
                     lock_step_in        = ST_INIT;
                     rsp_in.lock_outcome = OUT_NOT_HANDLED;
                  end
                  ST_ERROR: begin
                     lock_step_in        = ST_INIT;
                     rsp_in.lock_outcome = OUT_NOT_HANDLED;
                  end
                  ST_NO_RESPONSE: begin
                     nxt.state           = ZS_FREE;
                     nxt.donate          = 1'b0;
                     lock_step_in        = ST_INIT;
                     rsp_in.lock_outcome = OUT_NO_RESPONSE;
                  end
                  default: begin
                     lock_step_in = ST_INIT;
                  end
               endcase
            end
         end
         KIND_UNLOCK: begin
            if (zone_ok_ff && cur.state == ZS_MINE) begin
               rsp_in.send_valid = 1'b1;
               rsp_in.send_order = ORD_UNLOCK;
               nxt.state         = ZS_FREE;
               nxt.donate        = 1'b0;
            end
         end
         KIND_DONATE: begin
            nxt.donate = 1'b1;
         end
         KIND_PEER: begin
            priority case (order_type'(req_ff.msg_order))
               ORD_RESULT: begin
                  if (req_ff.msg_grant) begin
                     nxt.state = ZS_MINE;
                  end
               end
               ORD_TRY: begin
                  if (own == OWN_MINE) begin
                     rsp_in.send_valid = 1'b1;
                     rsp_in.send_order = ORD_RESULT;
                     if (cur.donate) begin
                        nxt.state         = ZS_PEER_OWNED;
                        rsp_in.send_grant = 1'b1;
                     end else begin
                        nxt.state  = ZS_FREE;
                        nxt.donate = 1'b0;
                     end
                  end else if (own == OWN_SHARED) begin
                     nxt.state = ZS_PEER_OWNED;
                  end
               end
               ORD_UNLOCK: begin
                  if (cur.state == ZS_PEER_OWNED) begin
                     nxt.state  = ZS_FREE;
                     nxt.donate = 1'b0;
                  end
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase

      if (rsp_in.send_valid) begin
         rsp_in.send_zone = req_ff.zone[2:0];
      end
      rsp_in.zone_status = zone_ok_ff ? nxt.state : ZS_FREE;
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// ----- sv/two_party_zone_lock_table_top.sv -----
// Zone lock table shared with one peer.
// req_bus carries one event per beat: lock poll, unlock, donate, peer message
// or status query, with zone, time and message fields. rsp_bus returns exactly
// one result beat per request: an optional message to the peer, the lock
// outcome of a poll and the addressed zone's state after the event.
// csr_we/csr_index/csr_wdata write the owner masks and the two time limits;
// write them only while no request is outstanding.
// A request first reads the table entry (registered memory read), then
// updates the entry and sequencer and loads the result register. The block
// takes a new request only after the previous one has passed its update
// step. A new request is taken while the previous result still waits; if
// the receiver stalls, the block holds in the update step until the result
// register frees up.
// Synchronous reset sets all zones free with donate clear, the sequencer to
// its initial step and the registers to their default values.
module two_party_zone_lock_table_top #(
   parameter int ZONES = tzl_pkg::ZONES_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   tzl_req_if.sink    req_bus,
   tzl_rsp_if.source  rsp_bus,
   input logic        csr_we,
   input logic [1:0]  csr_index,
   input logic [15:0] csr_wdata
);
   import tzl_pkg::*;

   tzl_cmd_type     cmd;
   req_payload_type req_data;
   rsp_payload_type rsp_data;

   assign req_data.kind      = req_bus.kind;
   assign req_data.zone      = req_bus.zone;
   assign req_data.limit_ms  = req_bus.limit_ms;
   assign req_data.now_ms    = req_bus.now_ms;
   assign req_data.msg_order = req_bus.msg_order;
   assign req_data.msg_grant = req_bus.msg_grant;

   tzl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd)
   );

   tzl_datapath #(
      .ZONES (ZONES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   assign rsp_bus.send_valid   = rsp_data.send_valid;
   assign rsp_bus.send_order   = rsp_data.send_order;
   assign rsp_bus.send_zone    = rsp_data.send_zone;
   assign rsp_bus.send_grant   = rsp_data.send_grant;
   assign rsp_bus.lock_outcome = rsp_data.lock_outcome;
   assign rsp_bus.zone_status  = rsp_data.zone_status;

endmodule
